### rtl/cnmd_pkg.sv
// Shared types, constants and register indexes for the crossing number minutia detector.
package cnmd_pkg;

   localparam int DEF_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT    = 4096;

   localparam int PIXEL_W  = 8;
   localparam int POS_X_W  = 10;
   localparam int POS_Y_W  = 12;
   localparam int CFG_W_W  = 11;
   localparam int CFG_H_W  = 13;
   localparam int SIZE_W   = 13;   // holds any clamped width or height

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = CSR_IDX_W'(1);

   localparam logic [CFG_W_W-1:0] RESET_IMAGE_WIDTH  = CFG_W_W'(640);
   localparam logic [CFG_H_W-1:0] RESET_IMAGE_HEIGHT = CFG_H_W'(480);

   localparam logic [PIXEL_W-1:0] PIXEL_BACKGROUND = 8'd255;
   localparam logic [PIXEL_W-1:0] PIXEL_CENTER     = 8'd0;

   localparam logic KIND_RIDGE_END   = 1'b0;
   localparam logic KIND_BIFURCATION = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

   // one stored neighborhood entry
   typedef struct packed {
      logic oriented;
      logic zero;
      logic ridge;
   } entry_type;

   typedef struct packed {
      logic               minutia_kind;
      logic [POS_X_W-1:0] pos_x;
      logic [POS_Y_W-1:0] pos_y;
   } minutia_type;

   typedef struct packed {
      logic        valid;
      minutia_type data;
   } push_type;

endpackage

### rtl/cnmd_ifs.sv
// Handshake channel interfaces for pixel input, minutia output and register writes.
interface cnmd_req_if;
   import cnmd_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic               block_oriented;
   modport source (output valid, output pixel, output block_oriented, input ready);
   modport sink   (input valid, input pixel, input block_oriented, output ready);
endinterface

interface cnmd_rsp_if;
   import cnmd_pkg::*;
   logic               valid;
   logic               ready;
   logic               minutia_kind;
   logic [POS_X_W-1:0] pos_x;
   logic [POS_Y_W-1:0] pos_y;
   modport source (output valid, output minutia_kind, output pos_x, output pos_y, input ready);
   modport sink   (input valid, input minutia_kind, input pos_x, input pos_y, output ready);
endinterface

interface cnmd_csr_if;
   import cnmd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/cnmd_front.sv
// Front end: size registers, raster counters, line store, 3x3 window and crossing number.
module cnmd_front #(
   parameter int MAX_WIDTH = cnmd_pkg::DEF_MAX_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   cnmd_req_if.sink                            req_ch,
   cnmd_csr_if.sink                            csr_ch,
   input  logic [cnmd_pkg::QUEUE_LVL_W-1:0]    queue_level,
   output cnmd_pkg::push_type                  push
);
   import cnmd_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAXW = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAXH = SIZE_W'(MAX_HEIGHT);
   localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(3);
   localparam logic [SIZE_W-1:0] TWO = SIZE_W'(2);

   logic [CFG_W_W-1:0] cfg_width_ff;
   logic [CFG_H_W-1:0] cfg_height_ff;
   logic [SIZE_W-1:0]  eff_w, eff_h, cfg_w13, cfg_h13;

   logic [XW-1:0]      col_ff, col_in;
   logic [POS_Y_W-1:0] row_ff, row_in;
   logic [SIZE_W-1:0]  col_next, row_next;
   logic               accept;

   // line store word: high entry is two rows up, low entry is one row up
   logic [5:0]         line_mem [MAX_WIDTH];
   logic [5:0]         rd_ff;

   logic               s1_valid_ff;
   entry_type          s1_cur_ff;
   logic [XW-1:0]      s1_x_ff;
   logic [POS_Y_W-1:0] s1_y_ff;

   logic [17:0]        win_ff, win_in;
   logic [8:0]         right_col, mid_col, left_col;
   entry_type          top_e, mid_e, center;
   logic [7:0]         ring;
   logic [3:0]         trans;
   logic [2:0]         cn;
   logic [SIZE_W-1:0]  x13, y13;
   logic               in_frame, hit;
   entry_type          cur_e;

   // size registers
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= RESET_IMAGE_WIDTH;
         cfg_height_ff <= RESET_IMAGE_HEIGHT;
      end else if (csr_ch.valid) begin
         if (csr_ch.index == CSR_IMAGE_WIDTH) begin
            cfg_width_ff <= csr_ch.data[CFG_W_W-1:0];
         end
         if (csr_ch.index == CSR_IMAGE_HEIGHT) begin
            cfg_height_ff <= csr_ch.data[CFG_H_W-1:0];
         end
      end
   end

   always_comb begin
      cfg_w13 = SIZE_W'(cfg_width_ff);
      cfg_h13 = SIZE_W'(cfg_height_ff);
      if (cfg_w13 < MIN_SIZE)   eff_w = MIN_SIZE;
      else if (cfg_w13 > MAXW)  eff_w = MAXW;
      else                      eff_w = cfg_w13;
      if (cfg_h13 < MIN_SIZE)   eff_h = MIN_SIZE;
      else if (cfg_h13 > MAXH)  eff_h = MAXH;
      else                      eff_h = cfg_h13;
   end

   // room for the item in flight and this one
   assign req_ch.ready = (SIZE_W'(queue_level) + SIZE_W'(s1_valid_ff)) < SIZE_W'(QUEUE_DEPTH);
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      cur_e.ridge    = (req_ch.pixel != PIXEL_BACKGROUND);
      cur_e.zero     = (req_ch.pixel == PIXEL_CENTER);
      cur_e.oriented = req_ch.block_oriented;
      col_next = SIZE_W'(col_ff) + SIZE_W'(1);
      row_next = SIZE_W'(row_ff) + SIZE_W'(1);
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_next >= eff_w) begin
            col_in = '0;
            row_in = (row_next >= eff_h) ? '0 : row_next[POS_Y_W-1:0];
         end else begin
            col_in = col_next[XW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
         win_ff      <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff     <= line_mem[col_ff];
         s1_cur_ff <= cur_e;
         s1_x_ff   <= col_ff;
         s1_y_ff   <= row_ff;
      end
      if (s1_valid_ff) begin
         line_mem[s1_x_ff] <= {rd_ff[2:0], s1_cur_ff};
      end
   end

   // window and crossing number on the item read last cycle
   always_comb begin
      top_e     = rd_ff[5:3];
      mid_e     = rd_ff[2:0];
      right_col = {s1_cur_ff, mid_e, top_e};
      mid_col   = win_ff[8:0];
      left_col  = win_ff[17:9];
      win_in    = s1_valid_ff ? {mid_col, right_col} : win_ff;
      center    = mid_col[5:3];
      // ring order E, NE, N, NW, W, SW, S, SE
      ring[0] = right_col[3];
      ring[1] = right_col[0];
      ring[2] = mid_col[0];
      ring[3] = left_col[0];
      ring[4] = left_col[3];
      ring[5] = left_col[6];
      ring[6] = mid_col[6];
      ring[7] = right_col[6];
      trans = '0;
      for (int n = 0; n < 8; n++) begin
         trans = trans + 4'(ring[n] ^ ring[(n + 1) % 8]);
      end
      cn = trans[3:1];
      x13 = SIZE_W'(s1_x_ff);
      y13 = SIZE_W'(s1_y_ff);
      in_frame = (x13 >= TWO) && (x13 < eff_w) && (y13 >= TWO) && (y13 < eff_h);
      hit = s1_valid_ff && in_frame && center.zero && center.oriented &&
            ((cn == 3'd1) || (cn == 3'd3));
   end

   always_comb begin
      push.valid             = hit;
      push.data.minutia_kind = (cn == 3'd3) ? KIND_BIFURCATION : KIND_RIDGE_END;
      push.data.pos_x        = POS_X_W'(x13 - SIZE_W'(1));
      push.data.pos_y        = POS_Y_W'(y13 - SIZE_W'(1));
   end

endmodule

### rtl/cnmd_queue.sv
// Back end: short result queue that drives the minutia output channel.
module cnmd_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  cnmd_pkg::push_type                push,
   output logic [cnmd_pkg::QUEUE_LVL_W-1:0]  level,
   cnmd_rsp_if.source                        rsp_ch
);
   import cnmd_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   minutia_type            slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]          wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_LVL_W-1:0] cnt_ff, cnt_in;
   logic                   pop;
   minutia_type            head;

   assign head                = slot_ff[rd_ff];
   assign rsp_ch.valid        = (cnt_ff != '0);
   assign rsp_ch.minutia_kind = head.minutia_kind;
   assign rsp_ch.pos_x        = head.pos_x;
   assign rsp_ch.pos_y        = head.pos_y;
   assign pop                 = rsp_ch.valid && rsp_ch.ready;
   assign level               = cnt_ff;

   always_comb begin
      wr_in  = push.valid ? PW'(wr_ff + PW'(1)) : wr_ff;
      rd_in  = pop ? PW'(rd_ff + PW'(1)) : rd_ff;
      cnt_in = cnt_ff + QUEUE_LVL_W'(push.valid) - QUEUE_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ff] <= push.data;
      end
   end

endmodule

### rtl/crossing_number_minutia_detector.sv
// Top level of the crossing number minutia detector.
//
//   channel  direction  carries
//   req_ch   in         pixel, block_oriented
//   rsp_ch   out        minutia_kind, pos_x, pos_y
//   csr_ch   in         index, data (image_width, image_height)
//
// One pixel per clock sustained while the result queue has room; a taken pixel's result
// passes through the registered line store read and the combinational classify into the queue.
// Reset clears counters, window and queue; the line store needs no clearing.
// A stalled output fills the four-entry result queue; req_ch.ready drops once queued and in-flight results reach four.
module crossing_number_minutia_detector #(
   parameter int MAX_WIDTH = cnmd_pkg::DEF_MAX_WIDTH
) (
   input  logic       clock,
   input  logic       reset,
   cnmd_req_if.sink   req_ch,
   cnmd_rsp_if.source rsp_ch,
   cnmd_csr_if.sink   csr_ch
);
   import cnmd_pkg::*;

   push_type               push;
   logic [QUEUE_LVL_W-1:0] level;

   cnmd_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_ch      (csr_ch),
      .queue_level (level),
      .push        (push)
   );

   cnmd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .level  (level),
      .rsp_ch (rsp_ch)
   );

endmodule
